/* rtl/frt_pkg.sv */
// frt_pkg: shared types, status codes and constants of the fragment reassembly tracker
// no dependencies; imported by every rtl/frt_* module and the top level

package frt_pkg;

   localparam int FRT_MAX_FRAGMENTS   = 16;
   localparam int FRT_HEADER_BYTES    = 16;
   localparam int FRT_DEFAULT_PAYLOAD = 65491;
   localparam int FRT_OFFSET_W        = 20;
   localparam int FRT_SIZE_W          = 21;

   typedef enum logic [2:0] {
      STATUS_END       = 3'd0,
      STATUS_MISMATCH  = 3'd1,
      STATUS_BAD_INDEX = 3'd2,
      STATUS_DUPLICATE = 3'd3,
      STATUS_ACCEPTED  = 3'd4,
      STATUS_COMPLETE  = 3'd5
   } status_type;

   typedef struct packed {
      logic [15:0]        datagram_length;
      logic [15:0]        fragment_index;
      logic [15:0]        fragment_count;
      logic [31:0]        frame_length;
      logic signed [63:0] timestamp;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [19:0]        write_offset;
      logic [15:0]        write_length;
      logic [19:0]        completed_size;
      logic signed [63:0] completed_timestamp;
   } rsp_type;

endpackage

/* rtl/fragment_reassembly_tracker.sv */
// fragment_reassembly_tracker: top level tying input register, core and result register
// depends on frt_pkg, frt_in_reg, frt_core and frt_out_reg
//
// usage:
//   req channel carries one parsed fragment header per transaction (req_valid,
//   req_stall, req_data); rsp channel returns exactly one result per header
//   (rsp_valid, rsp_stall, rsp_data) in arrival order.
//   csr channel writes the per-fragment payload size; csr_ready is always high,
//   write it only while no transaction is in flight.
//   rsp_valid rises once the header has passed the input register, the core and
//   the result register; a stalled result delays it.
//   throughput: one header per cycle unless a held result stalls the input; the
//   core's bitmap check and next-state logic are combinational between the registers.
//   reset (synchronous) empties both registers, clears the frame state and sets
//   the payload size to 65491.
//   while rsp_stall holds a result, one more header is taken into the input
//   register, after which req_stall rises until the result is taken.

module fragment_reassembly_tracker #(
   parameter int MAX_FRAGMENTS = frt_pkg::FRT_MAX_FRAGMENTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  frt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output frt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import frt_pkg::*;

   logic    in_valid, out_ready, fire;
   req_type in_data;
   rsp_type result;

   assign csr_ready = 1'b1;

   frt_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fire      (fire),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   frt_core #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .in_valid  (in_valid),
      .in_data   (in_data),
      .out_ready (out_ready),
      .fire      (fire),
      .result    (result)
   );

   frt_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // input side only backs up when a result is held by the receiver
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // every transaction through the core shows up as a result next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed header produced no result");

   // dropped or end transactions carry no write
   a_drop_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_END || rsp_data.status == STATUS_MISMATCH ||
                     rsp_data.status == STATUS_BAD_INDEX ||
                     rsp_data.status == STATUS_DUPLICATE))
      |-> (rsp_data.write_offset == '0 && rsp_data.write_length == '0 &&
           rsp_data.completed_size == '0))
      else $error("dropped transaction carries write fields");
`endif
endmodule

/* rtl/frt_in_reg.sv */
// frt_in_reg: input register holding one fragment header transaction
// depends on frt_pkg for req_type

module frt_in_reg (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  frt_pkg::req_type req_data,
   input  logic            fire,
   output logic            in_valid,
   output frt_pkg::req_type in_data
);
   import frt_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    accept;

   assign req_stall = valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;
endmodule

/* rtl/frt_core.sv */
// frt_core: frame state, payload size register and the per-fragment decision logic
// depends on frt_pkg for req_type, rsp_type, status codes and constants

module frt_core #(
   parameter int MAX_FRAGMENTS = frt_pkg::FRT_MAX_FRAGMENTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [15:0]      csr_data,
   input  logic             in_valid,
   input  frt_pkg::req_type in_data,
   input  logic             out_ready,
   output logic             fire,
   output frt_pkg::rsp_type result
);
   import frt_pkg::*;

   localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int OFF_W = IDX_W + 16;

   logic [15:0]                payload_ff;
   logic [15:0]                count_ff, count_in;
   logic signed [63:0]         stamp_ff, stamp_in;
   logic [MAX_FRAGMENTS-1:0]   bits_ff, bits_in;
   logic [31:0]                cap_ff, cap_in;
   logic [FRT_SIZE_W-1:0]      size_ff, size_in;

   // state as seen after a possible restart by index zero
   logic [15:0]                count_eff;
   logic signed [63:0]         stamp_eff;
   logic [MAX_FRAGMENTS-1:0]   bits_eff;
   logic [31:0]                cap_eff;
   logic [FRT_SIZE_W-1:0]      size_eff;

   logic                       is_end, restart, mismatch, bad_index, dup, done;
   logic [15:0]                payload;
   logic [IDX_W-1:0]           idx;
   logic [MAX_FRAGMENTS-1:0]   onehot, bits_new;
   logic [OFF_W-1:0]           offset;
   logic [32:0]                offset33, end33;
   logic [15:0]                copy;
   logic [FRT_SIZE_W-1:0]      size_new;

   assign fire = in_valid && out_ready;

   always_comb begin
      is_end   = in_data.datagram_length <= 16'(FRT_HEADER_BYTES);
      payload  = in_data.datagram_length - 16'(FRT_HEADER_BYTES);
      restart  = !is_end && (in_data.fragment_index == 16'd0);

      count_eff = count_ff;
      stamp_eff = stamp_ff;
      bits_eff  = bits_ff;
      cap_eff   = cap_ff;
      size_eff  = size_ff;
      if (restart) begin
         count_eff = in_data.fragment_count;
         stamp_eff = in_data.timestamp;
         bits_eff  = '0;
         size_eff  = '0;
         if (cap_ff < in_data.frame_length) begin
            cap_eff = in_data.frame_length;
         end
      end

      mismatch  = (count_eff != in_data.fragment_count) || (stamp_eff != in_data.timestamp);
      bad_index = (in_data.fragment_index >= in_data.fragment_count) ||
                  (32'(in_data.fragment_index) >= MAX_FRAGMENTS);
      idx       = in_data.fragment_index[IDX_W-1:0];
      dup       = bits_eff[idx];
      onehot    = '0;
      onehot[idx] = 1'b1;
      bits_new  = bits_eff | onehot;

      offset   = OFF_W'(idx) * OFF_W'(payload_ff);
      offset33 = 33'(offset);
      end33    = offset33 + 33'(payload);
      if (end33 <= {1'b0, cap_eff}) begin
         copy = payload;
      end else if (offset33 > {1'b0, cap_eff}) begin
         copy = '0;
      end else begin
         // room left is below the payload length here, so it fits 16 bits
         copy = 16'(cap_eff - offset33[31:0]);
      end
      size_new = size_eff + FRT_SIZE_W'(copy);

      // frames with a zero or oversized count never complete
      done = (count_eff != 16'd0) && (32'(count_eff) <= MAX_FRAGMENTS);
      for (int k = 0; k < MAX_FRAGMENTS; k++) begin
         if ((32'(k) < 32'(count_eff)) && !bits_new[k]) begin
            done = 1'b0;
         end
      end

      result   = '0;
      count_in = count_ff;
      stamp_in = stamp_ff;
      bits_in  = bits_ff;
      cap_in   = cap_ff;
      size_in  = size_ff;
      priority if (is_end) begin
         result.status = STATUS_END;
      end else if (mismatch) begin
         result.status = STATUS_MISMATCH;
      end else if (bad_index) begin
         result.status = STATUS_BAD_INDEX;
      end else if (dup) begin
         result.status = STATUS_DUPLICATE;
      end else begin
         result.status       = done ? STATUS_COMPLETE : STATUS_ACCEPTED;
         result.write_offset = offset33[FRT_OFFSET_W-1:0];
         result.write_length = copy;
         if (done) begin
            result.completed_size      = size_new[FRT_OFFSET_W-1:0];
            result.completed_timestamp = stamp_eff;
         end
      end

      if (!is_end) begin
         count_in = count_eff;
         stamp_in = stamp_eff;
         bits_in  = bits_eff;
         cap_in   = cap_eff;
         size_in  = size_eff;
         if (!mismatch && !bad_index && !dup) begin
            bits_in = bits_new;
            size_in = size_new;
            if (done) begin
               // buffer handed off; bitmap kept so repeats read as duplicates
               cap_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff <= 16'(FRT_DEFAULT_PAYLOAD);
         count_ff   <= '0;
         stamp_ff   <= '0;
         bits_ff    <= '0;
         cap_ff     <= '0;
         size_ff    <= '0;
      end else begin
         if (csr_valid) begin
            payload_ff <= csr_data;
         end
         if (fire) begin
            count_ff <= count_in;
            stamp_ff <= stamp_in;
            bits_ff  <= bits_in;
            cap_ff   <= cap_in;
            size_ff  <= size_in;
         end
      end
   end
endmodule

/* rtl/frt_out_reg.sv */
// frt_out_reg: result register toward the response channel
// depends on frt_pkg for rsp_type

module frt_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  frt_pkg::rsp_type result,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output frt_pkg::rsp_type rsp_data
);
   import frt_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = fire || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

/* tb/fragment_reassembly_tracker_test.sv */
// fragment_reassembly_tracker_test: self-checking testbench for the fragment reassembly tracker
// drives fragment headers and payload size writes, predicts each result and compares in order
// depends on rtl/frt_pkg.sv and rtl/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps

module fragment_reassembly_tracker_test;
   import frt_pkg::*;

   localparam int ITEM_TARGET = 950;
   localparam int QUIET_LIMIT = 2000;
   localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // tracker state as the block should hold it
   logic [15:0]        payload_bytes = 16'(FRT_DEFAULT_PAYLOAD);
   logic [15:0]        frame_count = '0;
   logic signed [63:0] frame_ts = '0;
   logic [15:0]        rx_bits = '0;
   logic [31:0]        capacity = '0;
   logic [20:0]        assembled = '0;

   rsp_type pending_results[$];
   int      error_count = 0;
   int      sent_items = 0;
   int      quiet_cycles = 0;
   bit      req_idling = 1'b1;
   bit      rsp_idling = 1'b1;
   bit      rsp_hold = 1'b0;
   int      rsp_run = 0;

   fragment_reassembly_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type track_fragment(input req_type f);
      rsp_type     r;
      longint      offset;
      longint      take;
      longint      payload;
      logic [16:0] need;
      r = '0;
      r.status = STATUS_END;
      if (f.datagram_length <= FRT_HEADER_BYTES) return r;
      payload = longint'(f.datagram_length) - FRT_HEADER_BYTES;
      // index zero restarts the frame
      if (f.fragment_index == 0) begin
         if (capacity < f.frame_length) capacity = f.frame_length;
         assembled = '0;
         frame_count = f.fragment_count;
         frame_ts = f.timestamp;
         rx_bits = '0;
      end
      if (frame_count != f.fragment_count || frame_ts != f.timestamp) begin
         r.status = STATUS_MISMATCH;
         return r;
      end
      if (f.fragment_index >= f.fragment_count || f.fragment_index >= FRT_MAX_FRAGMENTS) begin
         r.status = STATUS_BAD_INDEX;
         return r;
      end
      if (rx_bits[f.fragment_index]) begin
         r.status = STATUS_DUPLICATE;
         return r;
      end
      offset = longint'(f.fragment_index) * longint'(payload_bytes);
      take = payload;
      if (offset + payload > longint'(capacity)) take = longint'(capacity) - offset;
      if (take < 0) take = 0;
      assembled = assembled + take[20:0];
      rx_bits[f.fragment_index] = 1'b1;
      r.write_offset = offset[19:0];
      r.write_length = take[15:0];
      r.status = STATUS_ACCEPTED;
      if (frame_count > 0 && frame_count <= FRT_MAX_FRAGMENTS) begin
         need = (17'd1 << frame_count) - 17'd1;
         if ((rx_bits & need[15:0]) == need[15:0]) begin
            r.status = STATUS_COMPLETE;
            r.completed_size = assembled[19:0];
            r.completed_timestamp = frame_ts;
            capacity = '0;
         end
      end
      return r;
   endfunction

   // result stall pattern: alternating free and stalled runs, a few of them long
   always @(negedge clock) begin
      if (reset || !rsp_idling) begin
         rsp_stall <= 1'b0;
         rsp_hold = 1'b0;
         rsp_run = 0;
      end else begin
         if (rsp_run == 0) begin
            rsp_hold = !rsp_hold;
            if (rsp_hold)
               rsp_run = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 8)
                                                    : $urandom_range(3, 1);
            else
               rsp_run = $urandom_range(12, 1);
         end
         rsp_run = rsp_run - 1;
         rsp_stall <= rsp_hold;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result, status %0d", $realtime, rsp_data.status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.write_offset !== want.write_offset ||
                rsp_data.write_length !== want.write_length ||
                rsp_data.completed_size !== want.completed_size ||
                rsp_data.completed_timestamp !== want.completed_timestamp) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   status    exp %0d got %0d", want.status, rsp_data.status);
                  $display("   offset    exp %0d got %0d", want.write_offset,
                           rsp_data.write_offset);
                  $display("   length    exp %0d got %0d", want.write_length,
                           rsp_data.write_length);
                  $display("   size      exp %0d got %0d", want.completed_size,
                           rsp_data.completed_size);
                  $display("   timestamp exp %h got %h", want.completed_timestamp,
                           rsp_data.completed_timestamp);
               end
            end
         end
      end
   end

   // watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("** fragment_reassembly_tracker: FAILED **");
         $finish;
      end
   end

   task automatic req_pause();
      int pick;
      int gap;
      gap = 0;
      pick = $urandom_range(99, 0);
      if (req_idling) begin
         if (pick >= 92) gap = $urandom_range(30, 10);
         else if (pick >= 60) gap = $urandom_range(3, 1);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_header(input logic [15:0] dlen, input logic [15:0] idx,
                              input logic [15:0] count, input logic [31:0] flen,
                              input logic signed [63:0] stamp);
      req_type f;
      f.datagram_length = dlen;
      f.fragment_index = idx;
      f.fragment_count = count;
      f.frame_length = flen;
      f.timestamp = stamp;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(track_fragment(f));
      if (dlen > FRT_HEADER_BYTES) sent_items++;
      req_pause();
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_payload_size(input logic [15:0] size);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= size;
      do @(posedge clock); while (!csr_ready);
      payload_bytes = size;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // broken or stray headers mixed into a frame
   task automatic send_noise(input logic [15:0] count, input logic signed [63:0] stamp,
                             input logic [31:0] flen, input logic [15:0] idx);
      logic [15:0] body;
      body = 16'($urandom_range(65491, 1) + FRT_HEADER_BYTES);
      case ($urandom_range(5, 0))
         0: send_header(body, idx, count, flen, stamp);
         1: send_header(body, 16'($urandom_range(15, 1)), count, flen,
                        stamp ^ (64'sd1 << $urandom_range(63, 0)));
         2: send_header(body, 16'($urandom_range(15, 1)), count + 16'd1, flen, stamp);
         3: send_header(body, 16'($urandom_range(65535, count)), count, flen, stamp);
         4: send_header(16'($urandom_range(16, 0)), 16'($urandom), 16'($urandom),
                        $urandom, {$urandom, $urandom});
         default: send_header(16'($urandom_range(65507, 0)), 16'($urandom),
                              16'($urandom), $urandom, {$urandom, $urandom});
      endcase
   endtask

   // one frame: index zero first, the rest shuffled, some lost, some noise between
   task automatic send_frame();
      logic [15:0]        count;
      logic signed [63:0] stamp;
      logic [31:0]        flen;
      longint             body;
      int                 pick;
      int                 span;
      int                 j;
      int                 k;
      int                 tmp;
      int                 order[20];
      pick = $urandom_range(99, 0);
      if (pick < 60) count = 16'($urandom_range(4, 1));
      else if (pick < 85) count = 16'($urandom_range(16, 5));
      else if (pick < 93) count = 16'($urandom_range(24, 17));
      else if (pick < 96) count = 16'd0;
      else count = 16'($urandom);
      stamp = {$urandom, $urandom};
      if (pick % 16 == 1) stamp = TS_MAX;
      if (pick % 16 == 2) stamp = TS_MIN;
      span = (count == 0) ? 1 : ((count > 20) ? 20 : int'(count));
      if ($urandom_range(9, 0) < 7 && count != 0 && count <= FRT_MAX_FRAGMENTS)
         flen = 32'((int'(count) - 1) * int'(payload_bytes) +
                    int'($urandom_range(payload_bytes, 1)));
      else if ($urandom_range(3, 0) == 0)
         flen = $urandom;
      else
         flen = $urandom_range(200000, 0);
      for (j = 0; j < span; j++) order[j] = j;
      for (j = span - 1; j > 1; j--) begin
         k = $urandom_range(j, 1);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      for (j = 0; j < span; j++) begin
         if ($urandom_range(19, 0) == 0) continue;
         body = longint'(flen) - longint'(order[j]) * longint'(payload_bytes);
         if (body > payload_bytes) body = payload_bytes;
         if (body < 1 || $urandom_range(7, 0) == 0) body = $urandom_range(65491, 0);
         send_header(16'(body + FRT_HEADER_BYTES), 16'(order[j]), count, flen, stamp);
         if ($urandom_range(7, 0) == 0) send_noise(count, stamp, flen, 16'(order[j]));
      end
   endtask

   task automatic test_special_cases();
      // end signals leave the state alone
      send_header(16'd0, 16'd0, 16'd2, 32'd500, 64'sd0);
      send_header(16'd16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, TS_MAX);
      // two-fragment frame at the widest lengths, then a repeat after completion
      send_header(16'd65507, 16'd0, 16'd2, 32'hFFFF_FFFF, TS_MAX);
      send_header(16'd17, 16'd1, 16'd2, 32'hFFFF_FFFF, TS_MAX);
      send_header(16'd17, 16'd1, 16'd2, 32'd0, TS_MAX);
      // small capacity: second fragment lands past it and gets zero length
      send_header(16'd76, 16'd0, 16'd3, 32'd100, TS_MIN);
      send_header(16'd76, 16'd1, 16'd3, 32'd100, TS_MIN);
      send_header(16'd76, 16'd1, 16'd3, 32'd100, TS_MIN);
      send_header(16'd76, 16'd2, 16'd3, 32'd100, TS_MIN + 64'sd1);
      send_header(16'd76, 16'd2, 16'd4, 32'd100, TS_MIN);
      send_header(16'd76, 16'd3, 16'd3, 32'd100, TS_MIN);
      send_header(16'd76, 16'hFFFF, 16'd3, 32'd100, TS_MIN);
      send_header(16'd17, 16'd2, 16'd3, 32'd100, TS_MIN);
      // partial clamp to the capacity
      send_header(16'd1016, 16'd0, 16'd2, 32'd500, 64'sd7);
      send_header(16'd17, 16'd1, 16'd2, 32'd500, 64'sd7);
      // zero count and oversized count
      send_header(16'd17, 16'd0, 16'd0, 32'd0, 64'sd0);
      send_header(16'd100, 16'd0, 16'd20, 32'd0, 64'sd5);
      send_header(16'd100, 16'd15, 16'd20, 32'd0, 64'sd5);
      send_header(16'd100, 16'd16, 16'd20, 32'd0, 64'sd5);
      send_header(16'd65507, 16'd0, 16'hFFFF, 32'h0001_2345, -64'sd1);
      send_header(16'd200, 16'd0, 16'd1, 32'd1000, -64'sd1);
      send_header(16'd16, 16'd0, 16'd0, 32'd0, 64'sd0);
   endtask

   task automatic test_payload_sizes();
      logic [15:0] sizes[5];
      int          i;
      sizes = '{16'd1, 16'd65491, 16'd2, 16'd65490, 16'd1500};
      for (i = 0; i < 5; i++) begin
         write_payload_size(sizes[i]);
         send_frame();
         send_frame();
      end
   endtask

   task automatic test_streaming();
      int i;
      settle();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      for (i = 0; i < 10; i++) send_frame();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   task automatic test_random_traffic();
      int          pick;
      int          phase_end;
      logic [15:0] size;
      while (sent_items < ITEM_TARGET) begin
         pick = $urandom_range(9, 0);
         if (pick == 0) size = 16'd1;
         else if (pick == 1) size = 16'd65491;
         else if (pick < 5) size = 16'($urandom_range(64, 1));
         else if (pick < 8) size = 16'($urandom_range(4000, 500));
         else size = 16'($urandom_range(65491, 1));
         write_payload_size(size);
         req_idling = ($urandom_range(3, 0) != 0);
         rsp_idling = ($urandom_range(3, 0) != 0);
         phase_end = sent_items + 120;
         while (sent_items < phase_end && sent_items < ITEM_TARGET) send_frame();
      end
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_payload_sizes();
      test_streaming();
      test_random_traffic();
      settle();
      if (error_count == 0 && pending_results.size() == 0)
         $display("** fragment_reassembly_tracker: PASSED **");
      else
         $display("** fragment_reassembly_tracker: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
rtl/frt_pkg.sv
rtl/frt_in_reg.sv
rtl/frt_core.sv
rtl/frt_out_reg.sv
rtl/fragment_reassembly_tracker.sv
tb/fragment_reassembly_tracker_test.sv
